[rtl/core/spv_pkg.sv]
// ----------------------------------------------------------------------------
// spv_pkg
// Shared types and constants for the storage path validator.
// ----------------------------------------------------------------------------
package spv_pkg;

    localparam int PATH_LIMIT_DEF = 256;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_CTRL  = 8'h20;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_D     = 8'h64;

    localparam int PREFIX_LEN = 3;
    localparam logic [1:0] SEG_SAT = 2'd3;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       root_en;
    } t_item;

    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CHAR_SLASH;
            2'd1:    c = CHAR_S;
            2'd2:    c = CHAR_D;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/spv_in_reg.sv]
// ----------------------------------------------------------------------------
// spv_in_reg
// Input register stage: holds one path word until the check stage takes it.
// ----------------------------------------------------------------------------
module spv_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  spv_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_advance,
    output spv_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    spv_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) ? 1'b1 : (i_advance ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/spv_check.sv]
// ----------------------------------------------------------------------------
// spv_check
// Per-word path rule check with running state and the verdict register.
// ----------------------------------------------------------------------------
module spv_check #(
    parameter int PATH_LIMIT = spv_pkg::PATH_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  spv_pkg::t_item i_item,
    output logic           o_advance,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_path_valid
);

    localparam int CW = $clog2(PATH_LIMIT + 1);
    localparam logic [CW-1:0] LIMIT  = CW'(PATH_LIMIT);
    localparam logic [CW-1:0] PLEN   = CW'(spv_pkg::PREFIX_LEN);

    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_seg_len, n_seg_len;
    logic          r_all_dots, n_all_dots;
    logic          r_rejected, n_rejected;
    logic          r_out_valid, n_out_valid;
    logic          r_verdict, n_verdict;

    logic term;
    logic seg_bad;
    logic ok;
    logic [7:0] b;

    assign b         = i_item.path_byte;
    assign term      = (b == spv_pkg::CHAR_NUL);
    assign o_advance = i_valid && (!term || !r_out_valid || i_ready);
    assign seg_bad   = (r_seg_len == 2'd0) || (r_all_dots && r_seg_len <= 2'd2);

    always_comb begin
        if (r_count >= LIMIT || r_rejected || r_count < PLEN) begin
            ok = 1'b0;
        end else if (r_count == PLEN) begin
            ok = i_item.root_en;
        end else begin
            ok = !seg_bad;
        end
    end

    always_comb begin
        n_count    = r_count;
        n_seg_len  = r_seg_len;
        n_all_dots = r_all_dots;
        n_rejected = r_rejected;
        if (o_advance) begin
            if (term) begin
                n_count    = '0;
                n_seg_len  = 2'd0;
                n_all_dots = 1'b1;
                n_rejected = 1'b0;
            end else begin
                if (r_count < PLEN) begin
                    if (b != spv_pkg::prefix_char(r_count[1:0])) begin
                        n_rejected = 1'b1;
                    end
                end else if (r_count == PLEN) begin
                    if (b != spv_pkg::CHAR_SLASH) begin
                        n_rejected = 1'b1;
                    end
                    n_seg_len  = 2'd0;
                    n_all_dots = 1'b1;
                end else if (b == spv_pkg::CHAR_SLASH) begin
                    if (seg_bad) begin
                        n_rejected = 1'b1;
                    end
                    n_seg_len  = 2'd0;
                    n_all_dots = 1'b1;
                end else begin
                    if (b < spv_pkg::CHAR_CTRL || b == spv_pkg::CHAR_BSL) begin
                        n_rejected = 1'b1;
                    end
                    if (r_seg_len != spv_pkg::SEG_SAT) begin
                        n_seg_len = r_seg_len + 2'd1;
                    end
                    if (b != spv_pkg::CHAR_DOT) begin
                        n_all_dots = 1'b0;
                    end
                end
                if (r_count < LIMIT) begin
                    n_count = r_count + CW'(1);
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_verdict   = r_verdict;
        if (o_advance && term) begin
            n_out_valid = 1'b1;
            n_verdict   = ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_seg_len   <= 2'd0;
            r_all_dots  <= 1'b1;
            r_rejected  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_seg_len   <= n_seg_len;
            r_all_dots  <= n_all_dots;
            r_rejected  <= n_rejected;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign o_valid      = r_out_valid;
    assign o_path_valid = r_verdict;

endmodule

[rtl/core/storage_path_validator_core.sv]
// ----------------------------------------------------------------------------
// storage_path_validator_core
// Checks a byte-serial path against the "/sd" mount rules, one verdict/path.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_ready carry one path byte per word plus
// i_root_en. A zero byte ends the path; only then is i_root_en used.
// Output channel: o_valid/i_ready carry one o_path_valid word per path.
// Throughput: one input word per cycle while no terminator waits behind
// an untaken verdict, set by the single check stage that updates the
// running path state. The terminating word passes the input register,
// then the verdict register, before the verdict shows on o_valid.
// When the receiver stalls, the verdict holds in its register; non-zero
// bytes keep flowing, and a following terminator waits in the input
// register, which then drops o_ready until the verdict is taken.
// Reset (synchronous, active low) empties both registers and clears the
// path state; the block takes words as soon as reset is released.
// ----------------------------------------------------------------------------
module storage_path_validator_core #(
    parameter int PATH_LIMIT = spv_pkg::PATH_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_path_byte,
    input  logic       i_root_en,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_path_valid
);

    spv_pkg::t_item in_item;
    spv_pkg::t_item s1_item;
    logic           s1_valid;
    logic           s1_advance;

    assign in_item.path_byte = i_path_byte;
    assign in_item.root_en   = i_root_en;

    spv_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .o_valid   (s1_valid),
        .i_advance (s1_advance),
        .o_item    (s1_item)
    );

    spv_check #(
        .PATH_LIMIT (PATH_LIMIT)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s1_valid),
        .i_item       (s1_item),
        .o_advance    (s1_advance),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_path_valid (o_path_valid)
    );

endmodule

[rtl/core/spv_checker.sv]
// ----------------------------------------------------------------------------
// spv_checker
// Port-level checks for storage_path_validator_core, bound to the top level.
// ----------------------------------------------------------------------------
module spv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_path_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_path_valid))
        else $error("verdict dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid && o_ready)
        else $error("block not empty after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a pending verdict");

    a_nonterm_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> !o_valid || o_ready || !i_ready)
        else $error("input still stalled after verdict taken");

endmodule

bind storage_path_validator_core spv_checker u_spv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_path_valid (o_path_valid)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for storage_path_validator_core.
// Streams byte-serial paths into the core and predicts one verdict per zero
// byte with a local model of the mount-prefix, segment and length rules.
// Each verdict word is checked in order against the expected one. Stimulus
// runs directed prefix, segment, forbidden-byte and length-limit cases, then
// random paths. The sender idles in bursts and the receiver stalls on its own
// pattern.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT           = spv_pkg::PATH_LIMIT_DEF;
    localparam int RANDOM_WORDS    = 350;
    localparam int WATCHDOG_CYCLES = 1000;
    localparam int TAIL_CYCLES     = 8;
    localparam logic [7:0] MOUNT [spv_pkg::PREFIX_LEN] =
        '{spv_pkg::CHAR_SLASH, spv_pkg::CHAR_S, spv_pkg::CHAR_D};

    typedef logic [7:0] t_path [$];
    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_LONG} t_rx_mode;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_path_byte  = 8'h00;
    logic       i_root_en    = 1'b0;
    logic       i_ready      = 1'b1;
    logic       o_ready;
    logic       o_valid;
    logic       o_path_valid;

    storage_path_validator_core #(
        .PATH_LIMIT(LIMIT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_path_byte (i_path_byte),
        .i_root_en   (i_root_en),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_path_valid(o_path_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // path walker state
    int         path_len  = 0;
    logic [1:0] seg_len   = 2'd0;
    logic       seg_dots  = 1'b1;
    logic       path_bad  = 1'b0;
    logic       verdict_q [$];

    int       errors         = 0;
    int       words_sent     = 0;
    int       paths_sent     = 0;
    int       verdicts_seen  = 0;
    int       valid_verdicts = 0;
    int       stall_cycles   = 0;
    int       burst_left     = 0;
    bit       steady         = 1'b0;
    bit       valid_hi       = 1'b0;
    logic     want_verdict;
    t_rx_mode rx_mode        = RX_OPEN;
    int       rx_mode_left   = 200;
    int       rx_stall       = 0;

    function automatic logic segment_broken();
        return (seg_len == 2'd0) || (seg_dots && seg_len <= 2'd2);
    endfunction

    function automatic void walk_word(input logic [7:0] b, input logic ar);
        logic ok;
        if (b == spv_pkg::CHAR_NUL) begin
            if (path_len >= LIMIT || path_bad || path_len < spv_pkg::PREFIX_LEN) ok = 1'b0;
            else if (path_len == spv_pkg::PREFIX_LEN) ok = ar;
            else ok = !segment_broken();
            verdict_q.push_back(ok);
            path_len = 0;
            seg_len  = 2'd0;
            seg_dots = 1'b1;
            path_bad = 1'b0;
        end else begin
            if (path_len < spv_pkg::PREFIX_LEN) begin
                if (b != MOUNT[path_len]) path_bad = 1'b1;
            end else if (path_len == spv_pkg::PREFIX_LEN) begin
                if (b != spv_pkg::CHAR_SLASH) path_bad = 1'b1;
                seg_len  = 2'd0;
                seg_dots = 1'b1;
            end else if (b == spv_pkg::CHAR_SLASH) begin
                if (segment_broken()) path_bad = 1'b1;
                seg_len  = 2'd0;
                seg_dots = 1'b1;
            end else begin
                if (b < spv_pkg::CHAR_CTRL || b == spv_pkg::CHAR_BSL) path_bad = 1'b1;
                if (seg_len != spv_pkg::SEG_SAT) seg_len = seg_len + 2'd1;
                if (b != spv_pkg::CHAR_DOT) seg_dots = 1'b0;
            end
            if (path_len < LIMIT) path_len++;
        end
    endfunction

    task automatic idle_for(input int n);
        if (valid_hi) begin
            i_valid     <= 1'b0;
            i_path_byte <= 8'($urandom);
            i_root_en   <= 1'($urandom);
            valid_hi = 1'b0;
        end
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            if (!steady) idle_for($urandom_range(1, 6));
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic ar);
        i_valid     <= 1'b1;
        i_path_byte <= b;
        i_root_en   <= ar;
        valid_hi = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        walk_word(b, ar);
        words_sent++;
        pace();
    endtask

    task automatic send_path(input t_path p, input logic ar);
        foreach (p[i]) send_word(p[i], 1'($urandom));
        send_word(spv_pkg::CHAR_NUL, ar);
        paths_sent++;
    endtask

    function automatic t_path to_path(input string s);
        t_path p;
        for (int i = 0; i < s.len(); i++) p.push_back(s[i]);
        return p;
    endfunction

    function automatic t_path long_path(input int n);
        t_path p;
        p = to_path("/sd/");
        while (p.size() < n)
            p.push_back((p.size() % 20 == 0) ? spv_pkg::CHAR_SLASH : 8'h61);
        return p;
    endfunction

    function automatic logic [7:0] random_char();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0:       c = 8'($urandom_range(1, 255));
            1:       c = spv_pkg::CHAR_DOT;
            2:       c = 8'($urandom_range(8'h30, 8'h39));
            3:       c = 8'($urandom_range(8'h41, 8'h5A));
            default: c = 8'($urandom_range(8'h61, 8'h7A));
        endcase
        if (c == spv_pkg::CHAR_SLASH) c = spv_pkg::CHAR_BSL;
        return c;
    endfunction

    function automatic t_path random_path();
        t_path p;
        int    kind;
        int    n;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            n = $urandom_range(0, spv_pkg::PREFIX_LEN);
            for (int i = 0; i < n; i++) p.push_back(MOUNT[i]);
        end else if (kind < 20) begin
            if ($urandom_range(0, 1) == 0) p = to_path("/sd/");
            repeat ($urandom_range(0, 12)) p.push_back(8'($urandom_range(1, 255)));
        end else begin
            p = to_path("/sd/");
            n = $urandom_range(1, 4);
            for (int s = 0; s < n; s++) begin
                if (s > 0) p.push_back(spv_pkg::CHAR_SLASH);
                case ($urandom_range(0, 19))
                    0: ;
                    1: p.push_back(spv_pkg::CHAR_DOT);
                    2: repeat (2) p.push_back(spv_pkg::CHAR_DOT);
                    3: repeat ($urandom_range(3, 5)) p.push_back(spv_pkg::CHAR_DOT);
                    default: repeat ($urandom_range(1, 7)) p.push_back(random_char());
                endcase
            end
            if ($urandom_range(0, 19) == 0) p.push_back(spv_pkg::CHAR_SLASH);
            if ($urandom_range(0, 9) == 0)
                p[$urandom_range(0, p.size() - 1)] = 8'($urandom_range(1, 255));
        end
        return p;
    endfunction

    task automatic test_prefix_and_root();
        send_path(to_path("/sd"), 1'b1);
        send_path(to_path("/sd"), 1'b0);
        send_path(to_path(""), 1'b1);
        send_path(to_path(""), 1'b1);
        send_path(to_path("/s"), 1'b1);
        send_path(to_path("/sx/a"), 1'b1);
        send_path(to_path("xsd/a"), 1'b0);
        send_path(to_path("/sdx"), 1'b1);
    endtask

    task automatic test_segments();
        steady = 1'b1;
        send_path(to_path("/sd/a"), 1'b0);
        send_path(to_path("/sd/"), 1'b1);
        send_path(to_path("/sd//a"), 1'b0);
        send_path(to_path("/sd/a/"), 1'b0);
        send_path(to_path("/sd/."), 1'b1);
        send_path(to_path("/sd/.."), 1'b0);
        send_path(to_path("/sd/..."), 1'b0);
        send_path(to_path("/sd/.a/b."), 1'b0);
        send_path(to_path("/sd/a/../b"), 1'b1);
        send_path(to_path("/sd/segment_longer/x"), 1'b0);
        steady = 1'b0;
    endtask

    task automatic test_forbidden_bytes();
        send_path(to_path("/sd/a\\b"), 1'b1);
        send_path(to_path("/sd/a\037b"), 1'b0);
        send_path(to_path("/sd/\001"), 1'b0);
        send_path(to_path("/sd/ \177\200\377"), 1'b1);
    endtask

    task automatic test_length_limit();
        send_path(long_path(LIMIT - 1), 1'b1);
        send_path(long_path(LIMIT), 1'b1);
        send_path(long_path(LIMIT + 1), 1'b0);
        send_path(long_path(LIMIT + 40), 1'b1);
        send_path(to_path("/sd/ok"), 1'b0);
    endtask

    task automatic test_drain_pause();
        repeat (3) send_path(random_path(), 1'b1);
        idle_for(1);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) send_path(random_path(), 1'($urandom));
    endtask

    task automatic test_random_paths();
        int start;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            if ($urandom_range(0, 7) == 0) steady = !steady;
            send_path(random_path(), 1'($urandom));
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready      <= 1'b1;
            rx_stall     <= 0;
            rx_mode      <= RX_OPEN;
            rx_mode_left <= 200;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_mode'($urandom_range(0, 2));
                rx_mode_left <= $urandom_range(50, 400);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            if (rx_stall != 0) begin
                i_ready  <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                case (rx_mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_CHOPPY: i_ready <= 1'($urandom);
                    default: begin
                        if ($urandom_range(0, 19) == 0) begin
                            i_ready  <= 1'b0;
                            rx_stall <= $urandom_range(4, 30);
                        end else begin
                            i_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected verdict word: path_valid actual %0b", o_path_valid);
                errors++;
            end else begin
                want_verdict = verdict_q.pop_front();
                if (o_path_valid !== want_verdict) begin
                    $error("path_valid mismatch: expected %0b, actual %0b",
                           want_verdict, o_path_valid);
                    errors++;
                end
                verdicts_seen++;
                if (want_verdict) valid_verdicts++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_CYCLES);
        $display("watchdog: no handshake for %0d cycles, %0d verdicts outstanding",
                 stall_cycles, verdict_q.size());
        $display("[storage_path_validator_core] ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_prefix_and_root();
        test_segments();
        test_forbidden_bytes();
        test_length_limit();
        test_drain_pause();
        test_random_paths();
        idle_for(1);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d paths in %0d words: prefix, root, segment, forbidden-byte,",
                 paths_sent, words_sent);
        $display("length-limit and random paths; %0d verdicts checked, %0d valid, %0d errors.",
                 verdicts_seen, valid_verdicts, errors);
        if (errors == 0) begin
            $display("[storage_path_validator_core] OK");
        end else begin
            $display("[storage_path_validator_core] ERROR");
        end
        $finish;
    end

endmodule

[storage_path_validator_core.f]
rtl/core/spv_pkg.sv
rtl/core/spv_in_reg.sv
rtl/core/spv_check.sv
rtl/core/storage_path_validator_core.sv
rtl/core/spv_checker.sv
dv/tb_top.sv
